// ===== src/lbps_pkg.sv =====
// ----------------------------------------------------------------------------
// lbps_pkg: LED blink pattern sequencer package
// Segment ROM contents, pattern start table and shared types.
// ----------------------------------------------------------------------------
package lbps_pkg;

   localparam int NUM_PATTERNS = 6;
   localparam int ROM_DEPTH    = 32;
   localparam int POS_W        = $clog2(ROM_DEPTH);
   localparam int SEL_W        = 3;
   localparam int LEN_W        = 7;

   typedef logic [7:0]       seg_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [SEL_W-1:0] sel_type;

   localparam seg_type LEVEL_BIT   = 8'h80;
   localparam seg_type LENGTH_MASK = 8'h7F;
   localparam seg_type SEG_ON      = 8'h80;
   localparam seg_type SEG_OFF     = 8'h00;
   localparam seg_type SEG_END     = 8'h00;

   // run-length segments, a zero byte ends each pattern; unused tail reads as end
   localparam seg_type SEG_ROM [ROM_DEPTH] = '{
      SEG_ON  | 8'd8, SEG_OFF | 8'd2, SEG_END,
      SEG_ON  | 8'd3, SEG_OFF | 8'd3, SEG_END,
      SEG_ON  | 8'd1, SEG_OFF | 8'd1, SEG_END,
      SEG_OFF | 8'd2, SEG_ON  | 8'd2, SEG_OFF | 8'd6, SEG_END,
      SEG_OFF | 8'd2, SEG_ON  | 8'd2, SEG_OFF | 8'd2, SEG_ON | 8'd2,
      SEG_OFF | 8'd6, SEG_END,
      SEG_OFF | 8'd2, SEG_ON  | 8'd2, SEG_OFF | 8'd2, SEG_ON | 8'd2,
      SEG_OFF | 8'd2, SEG_ON  | 8'd2, SEG_OFF | 8'd6, SEG_END,
      SEG_END, SEG_END, SEG_END, SEG_END, SEG_END
   };

   // selections without a pattern start at pattern zero
   localparam pos_type PATTERN_START [2**SEL_W] = '{
      5'd0, 5'd3, 5'd6, 5'd9, 5'd13, 5'd19, 5'd0, 5'd0
   };

   function automatic pos_type start_of(input sel_type sel);
      pos_type res;
      res = (int'(sel) >= NUM_PATTERNS) ? PATTERN_START[0] : PATTERN_START[sel];
      return res;
   endfunction

endpackage

// ===== src/led_blink_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer
// Steps through run-length blink segments from a fixed ROM, at most one tick per item.
// ----------------------------------------------------------------------------
// Latency: a result item is valid the cycle after its request item is accepted.
// Throughput: one item per cycle unless rsp_tready stalls; the only path is one
//   ROM read, 7-bit count compare and next-address ROM read, state to result regs.
// Reset: synchronous; position goes to pattern zero start, count to zero,
//   LED on, pattern_select to zero, and no result is pending.
module led_blink_pattern_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] tick, [7:1] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [0] led_level, [1] segment_done,
                                             // [2] pattern_restart, [7:3] zero
   input  logic                 csr_we,
   input  logic [lbps_pkg::SEL_W-1:0] csr_wdata
);
   import lbps_pkg::*;

   sel_type sel_ff;
   pos_type pos_ff, pos_in;
   len_type count_ff, count_in;
   logic    led_ff, led_in;
   logic    rsp_valid_ff;
   logic    led_out_ff, done_ff, restart_ff;
   logic    done_in, restart_in;
   logic    accept;
   seg_type seg;
   len_type seg_len;
   pos_type pos_step;
   len_type count_step;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      seg        = SEG_ROM[pos_ff];
      seg_len    = seg[LEN_W-1:0];
      pos_in     = pos_ff;
      count_in   = count_ff;
      led_in     = led_ff;
      done_in    = 1'b0;
      restart_in = 1'b0;
      count_step = count_ff;
      pos_step   = pos_ff;
      if (req_tdata[0]) begin
         if (count_ff != seg_len) begin
            count_step = count_ff + len_type'(1);
            led_in     = |(seg & LEVEL_BIT);
         end
         if (count_step == seg_len) begin
            pos_step   = pos_ff + pos_type'(1);
            count_step = '0;
            done_in    = 1'b1;
         end
         pos_in   = pos_step;
         count_in = count_step;
         if (SEG_ROM[pos_step] == SEG_END) begin
            pos_in     = start_of(sel_ff);
            count_in   = '0;
            restart_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= '0;
         pos_ff       <= start_of('0);
         count_ff     <= '0;
         led_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            sel_ff <= csr_wdata;
         end
         if (accept) begin
            pos_ff   <= pos_in;
            count_ff <= count_in;
            led_ff   <= led_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         led_out_ff <= led_in;
         done_ff    <= done_in;
         restart_ff <= restart_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, restart_ff, done_ff, led_out_ff};

   // the position never rests on a pattern terminator
   a_pos_not_end: assert property (@(posedge clock) disable iff (reset)
      SEG_ROM[pos_ff] != SEG_END)
      else $error("position rests on a terminator");

   // count never runs past the current segment length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SEG_ROM[pos_ff][LEN_W-1:0])
      else $error("tick count beyond segment length");

   // a restart only follows a finished segment
   a_restart_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && restart_ff |-> done_ff)
      else $error("restart without segment done");

   // a hold item leaves the sequencer state alone
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tdata[0] |=> $stable(pos_ff) && $stable(count_ff) && $stable(led_ff))
      else $error("state changed on hold item");

   // an accepted item always produces a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("result missing after accept");

endmodule
